/* design/column_band_luma_concentrator_macros.svh */
// Assertion macros shared by the column band luma concentrator RTL.
// No dependencies; bodies fall away when SYNTHESIS is defined.
`ifndef COLUMN_BAND_LUMA_CONCENTRATOR_MACROS_SVH
`define COLUMN_BAND_LUMA_CONCENTRATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CBLC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cblc assertion failed");
`define CBLC_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("cblc forbidden condition seen");
`else
`define CBLC_ASSERT(label, clk, rst_n, prop)
`define CBLC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* design/cblc_pkg.sv */
// Shared constants and types of the column band luma concentrator.
// No dependencies; imported by every module of the block.
package cblc_pkg;

  localparam int MAX_ROWS      = 16;
  localparam int PIXEL_MAX     = 255;
  localparam int ROW_W         = $clog2(MAX_ROWS);
  localparam int CNT_W         = $clog2(MAX_ROWS + 1);
  localparam int LEVEL_W       = 8;
  localparam int GREY_W        = 8;
  localparam int BAND_W        = 5;
  localparam int SUM_W         = 12;
  localparam int BAND_ROWS_RST = 12;
  localparam int SEG_Q_DEPTH   = 2;
  localparam int SEG_Q_AW      = $clog2(SEG_Q_DEPTH);

  // One closed segment: its pixel total and its row count.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] rows;
  } seg_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } seg_q_stat_t;

endpackage

/* design/cblc_seg_queue.sv */
// Short queue of closed segment requests between front and back.
// Depends on cblc_pkg and the assertion macro header.
`include "column_band_luma_concentrator_macros.svh"
module cblc_seg_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  cblc_pkg::seg_desc_t   push_desc,
  input  logic                  pop,
  output cblc_pkg::seg_desc_t   head_desc,
  output cblc_pkg::seg_q_stat_t stat
);
  import cblc_pkg::*;

  seg_desc_t             entry_r [SEG_Q_DEPTH];
  logic [SEG_Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [SEG_Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [SEG_Q_AW:0]     count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head_desc  = entry_r[rd_ptr_r];
  assign stat.full  = (count_r == (SEG_Q_AW + 1)'(SEG_Q_DEPTH));
  assign stat.empty = (count_r == '0);

  `CBLC_ASSERT_NEVER(a_no_push_full, clk, rst_n, push && stat.full)
  `CBLC_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, pop && stat.empty)

endmodule

/* design/cblc_front.sv */
// Front end: band length register, pixel accumulation and segment close.
// Depends on cblc_pkg and the assertion macro header.
`include "column_band_luma_concentrator_macros.svh"
module cblc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic [cblc_pkg::BAND_W-1:0] cfg_data,
  input  logic                        in_push,
  input  logic [cblc_pkg::GREY_W-1:0] in_grey,
  input  logic                        in_end_of_segment,
  output logic                        in_full,
  input  cblc_pkg::seg_q_stat_t       q_stat,
  output logic                        q_push,
  output cblc_pkg::seg_desc_t         q_desc
);
  import cblc_pkg::*;

  logic [BAND_W-1:0] band_r, band_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt, sum_inc;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [CNT_W-1:0]  eff_rows;
  logic              accept;
  logic              close;

  // clamp band length into 1 .. MAX_ROWS
  always_comb begin
    if (band_r == '0) begin
      eff_rows = CNT_W'(1);
    end else if (band_r > BAND_W'(MAX_ROWS)) begin
      eff_rows = CNT_W'(MAX_ROWS);
    end else begin
      eff_rows = CNT_W'(band_r);
    end
  end

  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;
  assign sum_inc = sum_r + SUM_W'(in_grey);
  assign cnt_inc = cnt_r + 1'b1;
  assign close   = in_end_of_segment || (cnt_inc >= eff_rows);

  always_comb begin
    band_nxt = cfg_valid ? cfg_data : band_r;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    q_push   = 1'b0;
    if (accept) begin
      if (close) begin
        q_push  = 1'b1;
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_inc;
        cnt_nxt = cnt_inc;
      end
    end
  end

  assign q_desc.sum  = sum_inc;
  assign q_desc.rows = cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= BAND_W'(BAND_ROWS_RST);
      sum_r  <= '0;
      cnt_r  <= '0;
    end else begin
      band_r <= band_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  `CBLC_ASSERT(a_open_count_bound, clk, rst_n, cnt_r < CNT_W'(MAX_ROWS))

endmodule

/* design/cblc_back.sv */
// Back end: walks one closed segment row by row and emits its levels.
// Depends on cblc_pkg and the assertion macro header.
`include "column_band_luma_concentrator_macros.svh"
module cblc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cblc_pkg::seg_desc_t          q_desc,
  input  cblc_pkg::seg_q_stat_t        q_stat,
  output logic                         q_pop,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic [cblc_pkg::ROW_W-1:0]   out_row_offset,
  output logic [cblc_pkg::LEVEL_W-1:0] out_level,
  output logic                         out_last
);
  import cblc_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EMIT = 2'b10
  } back_state_t;

  back_state_t        state_r, state_nxt;
  seg_desc_t          desc_r, desc_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]   out_row_r, out_row_nxt;
  logic [LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic               out_last_r, out_last_nxt;
  logic               slot_free;
  logic               row_last;
  logic               emit;

  // level of one row: units fill from the centre outwards
  function automatic logic [LEVEL_W-1:0] level_of(
    input logic [ROW_W-1:0] row,
    input logic [CNT_W-1:0] rows,
    input logic [SUM_W-1:0] sum
  );
    logic [CNT_W-1:0] rows_m1;
    logic [ROW_W-1:0] up;
    logic [ROW_W-1:0] k;
    logic [ROW_W-1:0] m;
    logic             odd;
    logic             upper;
    logic [SUM_W-1:0] spent;
    logic [SUM_W-1:0] rest;
    logic [SUM_W-1:0] lvl;
    rows_m1 = rows - 1'b1;
    up      = rows_m1[ROW_W:1];
    odd     = rows[0];
    upper   = (row <= up);
    if (upper) begin
      k = up - row;
    end else if (odd) begin
      k = row - up;
    end else begin
      k = row - up - 1'b1;
    end
    if (odd) begin
      m = (k == '0) ? '0 : ({k[ROW_W-2:0], 1'b0} - 1'b1);
    end else begin
      m = {k[ROW_W-2:0], 1'b0};
    end
    spent = SUM_W'(m) * SUM_W'(PIXEL_MAX);
    rest  = (sum > spent) ? (sum - spent) : '0;
    if (odd && (k == '0)) begin
      lvl = (rest > SUM_W'(PIXEL_MAX)) ? SUM_W'(PIXEL_MAX) : rest;
    end else if (rest > SUM_W'(2 * PIXEL_MAX)) begin
      lvl = SUM_W'(PIXEL_MAX);
    end else if (upper) begin
      lvl = rest >> 1;
    end else begin
      lvl = rest - (rest >> 1);
    end
    return lvl[LEVEL_W-1:0];
  endfunction

  assign slot_free = !out_valid_r || out_pop;
  assign row_last  = (CNT_W'(row_r) == (desc_r.rows - 1'b1));

  always_comb begin
    state_nxt = state_r;
    desc_nxt  = desc_r;
    row_nxt   = row_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          desc_nxt  = q_desc;
          row_nxt   = '0;
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          if (row_last) begin
            if (!q_stat.empty) begin
              q_pop    = 1'b1;
              desc_nxt = q_desc;
              row_nxt  = '0;
            end else begin
              state_nxt = B_IDLE;
            end
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_level_nxt = out_level_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_row_nxt   = row_r;
      out_level_nxt = level_of(row_r, desc_r.rows, desc_r.sum);
      out_last_nxt  = row_last;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r      <= desc_nxt;
    row_r       <= row_nxt;
    out_row_r   <= out_row_nxt;
    out_level_r <= out_level_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_empty      = !out_valid_r;
  assign out_row_offset = out_row_r;
  assign out_level      = out_level_r;
  assign out_last       = out_last_r;

  `CBLC_ASSERT(a_row_in_seg, clk, rst_n, state_r == B_EMIT |-> CNT_W'(row_r) < desc_r.rows)

endmodule

/* design/column_band_luma_concentrator.sv */
// Column band luma concentrator: takes a pixel a cycle, emits a row a cycle unless stalled.
// A closed segment goes through the queue entry, the back descriptor and the output registers.
// Throughput: 1 pixel per cycle in and 1 row per cycle out while out_pop frees the slot,
// segments back to back; the front stalls only when the 2-entry segment queue is full.
// Reset (rst_n, synchronous, active low): clears the open segment, queue and output;
// band length returns to 12.
module column_band_luma_concentrator (
  input  logic                         clk,
  input  logic                         rst_n,
  // band length register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cblc_pkg::BAND_W-1:0]  cfg_data,
  // pixel input, queue style
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [cblc_pkg::GREY_W-1:0]  in_grey,
  input  logic                         in_end_of_segment,
  // redistributed rows, queue style
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [cblc_pkg::ROW_W-1:0]   out_row_offset,
  output logic [cblc_pkg::LEVEL_W-1:0] out_level,
  output logic                         out_last
);
  import cblc_pkg::*;

  // segment request handed from front to back
  seg_desc_t   push_desc;
  seg_desc_t   head_desc;
  seg_q_stat_t q_stat;
  logic        q_push;
  logic        q_pop;

  // the register is always writable; writes land the next edge
  assign cfg_ready = 1'b1;

  // Front: hold the band length, sum pixels of the open segment, and push a
  // request with the total and row count when the segment closes.
  cblc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .in_push           (in_push),
    .in_grey           (in_grey),
    .in_end_of_segment (in_end_of_segment),
    .in_full           (in_full),
    .q_stat            (q_stat),
    .q_push            (q_push),
    .q_desc            (push_desc)
  );

  // Queue: decouple accumulation of the next segment from emission of this one.
  cblc_seg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head_desc (head_desc),
    .stat      (q_stat)
  );

  // Back: advance one row per free output slot, computing each row's level
  // from its distance to the centre; drop nothing, repeat nothing.
  cblc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_desc         (head_desc),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_row_offset (out_row_offset),
    .out_level      (out_level),
    .out_last       (out_last)
  );

endmodule
